// ----- rtl/olex_pkg.sv -----
// ----------------------------------------------------------------------------
// olex_pkg: shared types and constants of the Oberon symbol lexer
// Scan modes, character codes, token and error codes, the result beat layout.
// ----------------------------------------------------------------------------
`default_nettype none

package olex_pkg;

  // Counter widths (defaults for the top level parameters)
  localparam int unsigned LineBitsDef   = 16;
  localparam int unsigned ColumnBitsDef = 16;

  // Result queue depth (two results per item at most)
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  // Scan mode
  typedef enum logic [2:0] {
    MODE_NORMAL       = 3'd0,
    MODE_LT           = 3'd1,
    MODE_GT           = 3'd2,
    MODE_COLON        = 3'd3,
    MODE_PAREN        = 3'd4,
    MODE_COMMENT      = 3'd5,
    MODE_COMMENT_STAR = 3'd6
  } scan_mode_e;

  // Character codes
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Token codes of the two-character and pending symbols
  localparam logic [4:0] TOK_LT     = 5'd13;
  localparam logic [4:0] TOK_GT     = 5'd14;
  localparam logic [4:0] TOK_COLON  = 5'd15;
  localparam logic [4:0] TOK_LPAREN = 5'd16;
  localparam logic [4:0] TOK_LE     = 5'd17;
  localparam logic [4:0] TOK_GE     = 5'd18;
  localparam logic [4:0] TOK_ASSIGN = 5'd19;

  // Error codes
  localparam logic ERR_UNEXPECTED   = 1'b0;
  localparam logic ERR_OPEN_COMMENT = 1'b1;

  // One result beat
  typedef struct packed {
    logic        is_error;
    logic [4:0]  token_kind;
    logic        error_kind;
    logic [7:0]  bad_char;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        last_of_run;
  } result_t;

  // Results of one accepted item
  typedef struct packed {
    logic    r0_valid;
    logic    r1_valid;
    result_t r0;
    result_t r1;
  } step_out_t;

  // Single-character symbols: {hit, code}
  function automatic logic [4:0] single_code(input logic [7:0] c);
    logic [4:0] r;
    case (c)
      8'h26:   r = {1'b1, 4'd0};   // &
      8'h2C:   r = {1'b1, 4'd1};   // ,
      8'h2E:   r = {1'b1, 4'd2};   // .
      8'h3D:   r = {1'b1, 4'd3};   // =
      8'h23:   r = {1'b1, 4'd4};   // #
      8'h5B:   r = {1'b1, 4'd5};   // [
      8'h2D:   r = {1'b1, 4'd6};   // -
      8'h2B:   r = {1'b1, 4'd7};   // +
      8'h5D:   r = {1'b1, 4'd8};   // ]
      8'h29:   r = {1'b1, 4'd9};   // )
      8'h3B:   r = {1'b1, 4'd10};  // ;
      8'h2A:   r = {1'b1, 4'd11};  // *
      8'h7E:   r = {1'b1, 4'd12};  // ~
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/olex_step.sv -----
// ----------------------------------------------------------------------------
// olex_step: next-state and result logic for one source character
// Mode update, saturating line/column counters and up to two result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module olex_step
  import olex_pkg::*;
#(
  parameter int unsigned LINE_BITS   = LineBitsDef,
  parameter int unsigned COLUMN_BITS = ColumnBitsDef
) (
  input  logic [7:0]             char_code_i,
  input  logic                   end_marker_i,
  input  logic                   report_columns_i,
  input  scan_mode_e             mode_i,
  input  logic [LINE_BITS-1:0]   line_i,
  input  logic [COLUMN_BITS-1:0] col_i,
  output scan_mode_e             mode_o,
  output logic [LINE_BITS-1:0]   line_o,
  output logic [COLUMN_BITS-1:0] col_o,
  output step_out_t              step_o
);

  localparam logic [LINE_BITS-1:0]   LineOne = LINE_BITS'(1);
  localparam logic [COLUMN_BITS-1:0] ColOne  = COLUMN_BITS'(1);

  // Saturate counters into the 16-bit result fields
  function automatic logic [15:0] line_sat(input logic [LINE_BITS-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'd65535) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [15:0] col_sat(input logic [COLUMN_BITS-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'd65535) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [COLUMN_BITS-1:0] col_inc(input logic [COLUMN_BITS-1:0] v);
    return (&v) ? v : v + ColOne;
  endfunction

  logic [COLUMN_BITS-1:0] col1, col2;
  logic [LINE_BITS-1:0]   line_inc;
  logic [15:0]            line16;
  logic [4:0]             single;
  logic                   pending;

  // Normal-mode character handler
  logic                   n_emit;
  result_t                n_res;
  scan_mode_e             n_mode;
  logic [COLUMN_BITS-1:0] n_col, n_base, n_next;
  logic [LINE_BITS-1:0]   n_line;

  result_t pend_tok;

  assign col1     = col_inc(col_i);
  assign col2     = col_inc(col1);
  assign line_inc = (&line_i) ? line_i : line_i + LineOne;
  assign line16   = line_sat(line_i);
  assign single   = single_code(char_code_i);

  // A pending symbol goes out alone ahead of the new character
  assign pending = !end_marker_i &&
                   (((mode_i == MODE_LT || mode_i == MODE_GT || mode_i == MODE_COLON) &&
                     char_code_i != CH_EQ) ||
                    (mode_i == MODE_PAREN && char_code_i != CH_STAR));

  // Column base of the handler: one further on when a pending symbol went out first
  assign n_base = pending ? col1 : col_i;
  assign n_next = pending ? col2 : col1;

  always_comb begin
    n_emit = 1'b0;
    n_res  = '0;
    n_mode = MODE_NORMAL;
    n_col  = n_base;
    n_line = line_i;
    n_res.line_number = line16;
    if (single[4]) begin
      n_emit           = 1'b1;
      n_res.token_kind = {1'b0, single[3:0]};
      n_col            = n_next;
    end else if (char_code_i == CH_LT) begin
      n_mode = MODE_LT;
    end else if (char_code_i == CH_GT) begin
      n_mode = MODE_GT;
    end else if (char_code_i == CH_COLON) begin
      n_mode = MODE_COLON;
    end else if (char_code_i == CH_LPAREN) begin
      n_mode = MODE_PAREN;
    end else if (char_code_i == CH_SPACE || char_code_i == CH_CR ||
                 char_code_i == CH_TAB) begin
      n_col = n_next;
    end else if (char_code_i == CH_NL) begin
      n_line = line_inc;
      n_col  = ColOne;
    end else begin
      n_emit              = 1'b1;
      n_res.is_error      = 1'b1;
      n_res.error_kind    = ERR_UNEXPECTED;
      n_res.bad_char      = char_code_i;
      n_res.column_number = report_columns_i ? col_sat(n_base) : 16'd0;
      n_col               = n_next;
    end
  end

  // Single symbol of the pending mode
  always_comb begin
    pend_tok             = '0;
    pend_tok.line_number = line16;
    case (mode_i)
      MODE_LT:    pend_tok.token_kind = TOK_LT;
      MODE_GT:    pend_tok.token_kind = TOK_GT;
      MODE_COLON: pend_tok.token_kind = TOK_COLON;
      MODE_PAREN: pend_tok.token_kind = TOK_LPAREN;
      default:    pend_tok.token_kind = TOK_LT;
    endcase
  end

  // Main mode update
  always_comb begin
    mode_o        = mode_i;
    line_o        = line_i;
    col_o         = col_i;
    step_o        = '0;
    step_o.r0.line_number = line16;
    step_o.r1     = n_res;
    if (end_marker_i) begin
      case (mode_i)
        MODE_LT, MODE_GT, MODE_COLON, MODE_PAREN: begin
          step_o.r0_valid = 1'b1;
          step_o.r0       = pend_tok;
        end
        MODE_COMMENT, MODE_COMMENT_STAR: begin
          step_o.r0_valid            = 1'b1;
          step_o.r0.is_error         = 1'b1;
          step_o.r0.error_kind       = ERR_OPEN_COMMENT;
          step_o.r0.column_number    = report_columns_i ? col_sat(col_i) : 16'd0;
        end
        default: ;
      endcase
      mode_o = MODE_NORMAL;
      line_o = LineOne;
      col_o  = ColOne;
    end else begin
      case (mode_i)
        MODE_LT, MODE_GT, MODE_COLON: begin
          step_o.r0_valid = 1'b1;
          if (char_code_i == CH_EQ) begin
            step_o.r0 = pend_tok;
            case (mode_i)
              MODE_LT: step_o.r0.token_kind = TOK_LE;
              MODE_GT: step_o.r0.token_kind = TOK_GE;
              default: step_o.r0.token_kind = TOK_ASSIGN;
            endcase
            col_o  = col2;
            mode_o = MODE_NORMAL;
          end else begin
            step_o.r0       = pend_tok;
            step_o.r1_valid = n_emit;
            mode_o          = n_mode;
            line_o          = n_line;
            col_o           = n_col;
          end
        end
        MODE_PAREN: begin
          if (char_code_i == CH_STAR) begin
            col_o  = col2;
            mode_o = MODE_COMMENT;
          end else begin
            step_o.r0_valid = 1'b1;
            step_o.r0       = pend_tok;
            step_o.r1_valid = n_emit;
            mode_o          = n_mode;
            line_o          = n_line;
            col_o           = n_col;
          end
        end
        MODE_COMMENT, MODE_COMMENT_STAR: begin
          if (char_code_i == CH_NL) begin
            line_o = line_inc;
            col_o  = ColOne;
            mode_o = MODE_COMMENT;
          end else begin
            col_o = col1;
            if (char_code_i == CH_STAR) begin
              mode_o = MODE_COMMENT_STAR;
            end else if (char_code_i == CH_RPAREN && mode_i == MODE_COMMENT_STAR) begin
              mode_o = MODE_NORMAL;
            end else begin
              mode_o = MODE_COMMENT;
            end
          end
        end
        default: begin
          step_o.r0_valid = n_emit;
          step_o.r0       = n_res;
          mode_o          = n_mode;
          line_o          = n_line;
          col_o           = n_col;
        end
      endcase
    end
    // Mark the final beat of this item
    step_o.r0.last_of_run = ~step_o.r1_valid;
    step_o.r1.last_of_run = 1'b1;
  end

endmodule

`default_nettype wire

// ----- rtl/oberon_symbol_lexer.sv -----
// ----------------------------------------------------------------------------
// oberon_symbol_lexer: operator-token lexer for Oberon-0 source text
// One source character per input beat; emits operator tokens and errors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries char_code_i and
//   end_marker_i. Output channel (out_valid_o/out_ready_i) carries one
//   token or error per beat; last_of_run_o marks the final beat of an item.
//   cfg_we_i/cfg_wdata_i writes report_columns (reset 1).
// Output: results are written into the 4-entry queue, read from its head.
// Throughput: one character per cycle while two queue entries are free;
//   an item with two results (pending symbol flushed plus a new token or
//   error) sends them one per beat through the single result port.
// Reset: mode normal, line and column 1, queue empty, report_columns 1.
//   No clearing pass; the block is ready as soon as reset is released.
// Stall: while out_ready_i is low the queue fills; in_ready_o drops once
//   fewer than two entries are free, so no result is ever lost.
// End marker: flushes a pending symbol or reports an open comment, then
//   returns line and column to 1 for the next source.
// ----------------------------------------------------------------------------
`default_nettype none

module oberon_symbol_lexer
  import olex_pkg::*;
#(
  parameter int unsigned LINE_BITS   = LineBitsDef,
  parameter int unsigned COLUMN_BITS = ColumnBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // input beats
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_marker_i,
  // output beats
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_error_o,
  output logic [4:0]  token_kind_o,
  output logic        error_kind_o,
  output logic [7:0]  bad_char_o,
  output logic [15:0] line_number_o,
  output logic [15:0] column_number_o,
  output logic        last_of_run_o
);

  localparam logic [QueueAw:0] QueueFull = (QueueAw+1)'(QueueDepth);

  logic                   report_q;
  scan_mode_e             mode_q, mode_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] col_q, col_d;
  step_out_t              step;

  result_t                queue_q [QueueDepth];
  logic [QueueAw-1:0]     wr_q, rd_q;
  logic [QueueAw:0]       count_q, count_d;
  logic                   in_fire, out_fire;
  logic [QueueAw:0]       push_n;
  result_t                head;

  assign in_fire  = in_valid_i & in_ready_o;
  assign out_fire = out_valid_o & out_ready_i;

  // Room for two results before an item is taken
  assign in_ready_o  = (count_q <= QueueFull - (QueueAw+1)'(2));
  assign out_valid_o = (count_q != '0);

  // Per-character logic
  olex_step #(
    .LINE_BITS  (LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS)
  ) u_step (
    .char_code_i     (char_code_i),
    .end_marker_i    (end_marker_i),
    .report_columns_i(report_q),
    .mode_i          (mode_q),
    .line_i          (line_q),
    .col_i           (col_q),
    .mode_o          (mode_d),
    .line_o          (line_d),
    .col_o           (col_d),
    .step_o          (step)
  );

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_q <= 1'b1;
    end else if (cfg_we_i) begin
      report_q <= cfg_wdata_i;
    end
  end

  // Scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      line_q <= LINE_BITS'(1);
      col_q  <= COLUMN_BITS'(1);
    end else if (in_fire) begin
      mode_q <= mode_d;
      line_q <= line_d;
      col_q  <= col_d;
    end
  end

  // Result queue control
  assign push_n  = in_fire ? ((QueueAw+1)'(step.r0_valid) + (QueueAw+1)'(step.r1_valid))
                           : '0;
  assign count_d = count_q + push_n - (QueueAw+1)'(out_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + push_n[QueueAw-1:0];
      rd_q    <= rd_q + QueueAw'(out_fire);
      count_q <= count_d;
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (in_fire && step.r0_valid) begin
      queue_q[wr_q] <= step.r0;
    end
    if (in_fire && step.r1_valid) begin
      queue_q[wr_q + QueueAw'(1)] <= step.r1;
    end
  end

  assign head            = queue_q[rd_q];
  assign is_error_o      = head.is_error;
  assign token_kind_o    = head.token_kind;
  assign error_kind_o    = head.error_kind;
  assign bad_char_o      = head.bad_char;
  assign line_number_o   = head.line_number;
  assign column_number_o = head.column_number;
  assign last_of_run_o   = head.last_of_run;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QueueFull)
    else $error("result queue overflow");

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && end_marker_i |=> line_q == LINE_BITS'(1) && col_q == COLUMN_BITS'(1)
                                && mode_q == MODE_NORMAL)
    else $error("end marker did not restore scan state");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && step.r1_valid |-> step.r0_valid && !step.r0.last_of_run)
    else $error("second result without a leading first result");

endmodule

`default_nettype wire
